@@ rtl/pcxrle_pkg.sv @@
`timescale 1ns / 1ps
// types, constants and the run-closing helper shared by the PCX/EFP run-length encoder
// no dependencies

package pcxrle_pkg;

    // run limits and code bytes
    localparam logic [5:0] MAX_RUN       = 6'd63;
    localparam logic [7:0] RUN_BASE      = 8'd192;
    localparam logic [7:0] PCX_THRESHOLD = 8'hC0;
    localparam logic [7:0] EFP_THRESHOLD = 8'd193;
    localparam logic [7:0] PCX_TRAILER   = 8'h0C;

    // format modes
    localparam logic MODE_PCX = 1'b0;
    localparam logic MODE_EFP = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_MODE = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_ROW  = 4'd1;
    localparam logic [15:0] ROW_WIDTH_RESET = 16'd320;

    // command queue depth
    localparam int unsigned FIFO_DEPTH = 4;

    // one closed run, as handed from the front to the back
    typedef struct packed {
        logic [7:0] head;     // literal pixel or count byte
        logic [7:0] value;    // run value, sent after head when pair is set
        logic       pair;     // two-byte form
        logic       trailer;  // trailer byte follows
        logic       last;     // final byte of this command ends the image
    } cmd_t;

    // front status seen at the top level
    typedef struct packed {
        logic pend;      // second command of an item still waiting
        logic run_open;  // a run is open
    } front_stat_t;

    // build the command for a run of len pixels of val
    function automatic cmd_t make_cmd(input logic [5:0] len, input logic [7:0] val,
                                      input logic mode, input logic trl, input logic lst);
        cmd_t       c;
        logic [7:0] thr;
        thr       = (mode == MODE_EFP) ? EFP_THRESHOLD : PCX_THRESHOLD;
        c.value   = val;
        c.trailer = trl;
        c.last    = lst;
        if (len == 6'd1 && val < thr) begin
            c.head = val;
            c.pair = 1'b0;
        end else begin
            c.head = RUN_BASE + {2'b00, len};
            c.pair = 1'b1;
        end
        return c;
    endfunction

endpackage

@@ rtl/pcxrle_front.sv @@
`timescale 1ns / 1ps
// front part: configuration registers, run tracking and closed-run commands
// depends on pcxrle_pkg

module pcxrle_front #(
    parameter int unsigned COLUMN_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pcxrle_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [15:0]                        cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,
    input  logic                               s_tlast,
    input  logic                               fifo_full,
    output logic                               push_valid,
    output pcxrle_pkg::cmd_t                   push_cmd,
    output pcxrle_pkg::front_stat_t            stat
);

    logic                   mode_reg, mode_next;
    logic [15:0]            row_width_reg, row_width_next;
    logic [7:0]             run_value_reg, run_value_next;
    logic [5:0]             run_len_reg, run_len_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic                   pend_reg, pend_next;
    pcxrle_pkg::cmd_t       pend_cmd_reg, pend_cmd_next;

    logic                   accept;
    logic                   flush1, flush2, start, row_end;
    logic [5:0]             len1;
    logic [7:0]             val1;
    logic [COLUMN_BITS-1:0] col_inc;
    pcxrle_pkg::cmd_t       cmd1, cmd2;

    assign cfg_ready = 1'b1;
    assign s_tready  = !pend_reg && !fifo_full;
    assign accept    = s_tvalid && s_tready;
    assign stat.pend     = pend_reg;
    assign stat.run_open = (run_len_reg != 6'd0);

    // classify the incoming pixel
    always_comb begin
        flush1  = (run_len_reg != 6'd0) &&
                  ((s_tdata != run_value_reg) || (run_len_reg >= pcxrle_pkg::MAX_RUN));
        start   = flush1 || (run_len_reg == 6'd0);
        len1    = start ? 6'd1 : run_len_reg + 6'd1;
        val1    = start ? s_tdata : run_value_reg;
        col_inc = col_reg + {{(COLUMN_BITS-1){1'b0}}, 1'b1};
        row_end = (mode_reg == pcxrle_pkg::MODE_PCX) &&
                  (col_inc == row_width_reg[COLUMN_BITS-1:0]);
        flush2  = row_end || s_tlast;
        cmd1    = pcxrle_pkg::make_cmd(run_len_reg, run_value_reg, mode_reg, 1'b0, 1'b0);
        cmd2    = pcxrle_pkg::make_cmd(len1, val1, mode_reg,
                                       s_tlast && (mode_reg == pcxrle_pkg::MODE_PCX),
                                       s_tlast);
    end

    // queue push: a held second command goes first
    always_comb begin
        if (pend_reg) begin
            push_valid = !fifo_full;
            push_cmd   = pend_cmd_reg;
        end else begin
            push_valid = accept && (flush1 || flush2);
            push_cmd   = flush1 ? cmd1 : cmd2;
        end
    end

    // next state
    always_comb begin
        mode_next      = mode_reg;
        row_width_next = row_width_reg;
        run_value_next = run_value_reg;
        run_len_next   = run_len_reg;
        col_next       = col_reg;
        pend_next      = pend_reg;
        pend_cmd_next  = pend_cmd_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == pcxrle_pkg::CFG_IDX_MODE) begin
                mode_next = cfg_data[0];
            end else if (cfg_index == pcxrle_pkg::CFG_IDX_ROW) begin
                row_width_next = cfg_data;
            end
        end
        if (pend_reg && !fifo_full) begin
            pend_next = 1'b0;
        end
        if (accept) begin
            run_value_next = val1;
            run_len_next   = flush2 ? 6'd0 : len1;
            col_next       = ((mode_reg != pcxrle_pkg::MODE_PCX) || flush2) ?
                             '0 : col_inc;
            pend_next      = flush1 && flush2;
            pend_cmd_next  = cmd2;
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= pcxrle_pkg::MODE_PCX;
            row_width_reg <= pcxrle_pkg::ROW_WIDTH_RESET;
            run_value_reg <= 8'd0;
            run_len_reg   <= 6'd0;
            col_reg       <= '0;
            pend_reg      <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            row_width_reg <= row_width_next;
            run_value_reg <= run_value_next;
            run_len_reg   <= run_len_next;
            col_reg       <= col_next;
            pend_reg      <= pend_next;
        end
    end

    // held command payload
    always_ff @(posedge aclk) begin
        pend_cmd_reg <= pend_cmd_next;
    end

endmodule

@@ rtl/pcxrle_fifo.sv @@
`timescale 1ns / 1ps
// short command queue between the front and back parts
// depends on pcxrle_pkg

module pcxrle_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  pcxrle_pkg::cmd_t push_cmd,
    input  logic             pop,
    output pcxrle_pkg::cmd_t head_cmd,
    output logic             empty,
    output logic             full
);

    localparam int unsigned PTR_BITS = $clog2(pcxrle_pkg::FIFO_DEPTH);
    localparam int unsigned CNT_BITS = $clog2(pcxrle_pkg::FIFO_DEPTH + 1);

    pcxrle_pkg::cmd_t    mem [pcxrle_pkg::FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_BITS'(pcxrle_pkg::FIFO_DEPTH));
    assign head_cmd = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + {{(PTR_BITS-1){1'b0}}, 1'b1};
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + {{(PTR_BITS-1){1'b0}}, 1'b1};
            end
            if (push && !pop) begin
                count_reg <= count_reg + {{(CNT_BITS-1){1'b0}}, 1'b1};
            end else if (pop && !push) begin
                count_reg <= count_reg - {{(CNT_BITS-1){1'b0}}, 1'b1};
            end
        end
    end

endmodule

@@ rtl/pcxrle_back.sv @@
`timescale 1ns / 1ps
// back part: expands commands into code bytes behind an output register
// depends on pcxrle_pkg

module pcxrle_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  pcxrle_pkg::cmd_t head_cmd,
    input  logic             empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    logic [1:0] phase_reg, phase_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic       last_reg;

    logic       load, emit, final_byte;
    logic [1:0] last_phase;
    logic [7:0] cur_byte;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    // pick the byte of the current command
    always_comb begin
        load       = !valid_reg || m_tready;
        emit       = load && !empty;
        last_phase = {1'b0, head_cmd.pair} + {1'b0, head_cmd.trailer};
        final_byte = (phase_reg == last_phase);
        pop        = emit && final_byte;
        case (phase_reg)
            2'd0:    cur_byte = head_cmd.head;
            2'd1:    cur_byte = head_cmd.pair ? head_cmd.value : pcxrle_pkg::PCX_TRAILER;
            default: cur_byte = pcxrle_pkg::PCX_TRAILER;
        endcase
        phase_next = phase_reg;
        if (emit) begin
            phase_next = final_byte ? 2'd0 : phase_reg + 2'd1;
        end
        valid_next = load ? !empty : valid_reg;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            data_reg <= cur_byte;
            last_reg <= head_cmd.last && final_byte;
        end
    end

endmodule

@@ rtl/pcx_style_rle_encoder_unit.sv @@
`timescale 1ns / 1ps
// top level of the PCX/EFP style run-length encoder
// depends on pcxrle_pkg, pcxrle_front, pcxrle_fifo, pcxrle_back
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    s_tdata = pixel, s_tlast = last_pixel
// m_*       out  m_tvalid/m_tready    m_tdata = code_byte, m_tlast = last_byte
// cfg_*     in   cfg_valid/cfg_ready  cfg_index = register, cfg_data = value
//
// the front takes a pixel, but stalls s_tready when it closes two runs at once
// the back sends one code byte per cycle unless stalled by m_tready or an empty
// queue, 0 to 5 bytes per pixel; the output byte port sets the sustained rate
// a 4-entry command queue lets front and back stall independently
// reset clears runs, column count and queue; format_mode = 0, row_width = 320
// cfg_ready is always high

module pcx_style_rle_encoder_unit #(
    parameter int unsigned COLUMN_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcxrle_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [15:0]                         cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] pixel
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] code_byte
    output logic                                m_tlast
);

    logic                    push_valid, fifo_pop, fifo_empty, fifo_full;
    pcxrle_pkg::cmd_t        push_cmd, head_cmd;
    pcxrle_pkg::front_stat_t front_stat;

    // pixel classification and run tracking
    pcxrle_front #(
        .COLUMN_BITS(COLUMN_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fifo_full (fifo_full),
        .push_valid(push_valid),
        .push_cmd  (push_cmd),
        .stat      (front_stat)
    );

    // command queue
    pcxrle_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push_valid),
        .push_cmd(push_cmd),
        .pop     (fifo_pop),
        .head_cmd(head_cmd),
        .empty   (fifo_empty),
        .full    (fifo_full)
    );

    // byte expansion
    pcxrle_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head_cmd(head_cmd),
        .empty   (fifo_empty),
        .pop     (fifo_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // back never pops an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_pop |-> !fifo_empty)
        else $error("command popped from empty queue");

    // the last pixel of an image leaves no run open
    a_last_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !front_stat.run_open)
        else $error("run still open after last pixel");

    // a held second command enters the queue as soon as there is room
    a_pend_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (front_stat.pend && !fifo_full) |=> !front_stat.pend)
        else $error("held command not pushed");

endmodule
